// File: sv/gzsf_pkg.sv
// ============================================================================
// gzsf_pkg
// Shared types and constants for the Gouraud span fill with inverse-depth store.
// ============================================================================
`default_nettype none
package gzsf_pkg;
  localparam int Width = 320;
  localparam int Height = 240;
  localparam int ChunkThreshold = 5;
  localparam int StoreSize = Width * Height;
  localparam int AddrW = $clog2(StoreSize);

  typedef enum logic [1:0] {
    FUNC_DRAW  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic signed [11:0] x_start;
    logic [7:0]  row;
    logic [10:0] span_length;
    logic [23:0] ids;
    logic [23:0] ide;
    logic [7:0]  rs;
    logic [7:0]  gs;
    logic [7:0]  bs;
    logic [7:0]  re;
    logic [7:0]  ge;
    logic [7:0]  be;
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);
endpackage
`default_nettype wire

// File: sv/gzsf_front.sv
// ============================================================================
// gzsf_front
// Command queue: holds accepted words until the back end takes them.
// ============================================================================
`default_nettype none
module gzsf_front
  import gzsf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire cmd_t in_cmd,
  output logic      q_valid,
  input  wire logic q_take,
  output cmd_t      q_cmd
);
  cmd_t        mem_r [2];
  logic [1:0]  cnt_r;
  logic        wp_r;
  logic        rp_r;
  logic        push;
  logic        pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop = q_take && q_valid;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: sv/gzsf_div.sv
// ============================================================================
// gzsf_div
// Restoring divider, one quotient bit per cycle, unsigned 36 by 12 bits.
// ============================================================================
`default_nettype none
module gzsf_div
  import gzsf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [35:0] num,
  input  wire logic [11:0] den,
  output logic             done,
  output logic [35:0]      quo
);
  logic [35:0] q_r;
  logic [12:0] rem_r;
  logic [11:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [12:0] trial;
  logic [12:0] shifted;

  assign shifted = {rem_r[11:0], q_r[35]};
  assign trial = shifted - {1'b0, den_r};
  assign quo = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_r <= num;
        rem_r <= 13'd0;
        den_r <= den;
        cnt_r <= 6'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!trial[12]) begin
          rem_r <= trial;
          q_r <= {q_r[34:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r <= {q_r[34:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd35) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/gzsf_back.sv
// ============================================================================
// gzsf_back
// Executes draw, clear, read and no-op words against the color and depth stores.
// ============================================================================
`default_nettype none
module gzsf_back
  import gzsf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_take,
  input  wire cmd_t        q_cmd,
  input  wire logic [23:0] bg_color,
  input  wire logic [7:0]  min_int,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_pixels_written,
  output logic [23:0]      out_read_color,
  output logic [23:0]      out_read_depth
);
  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_IDIV, S_STEP_START, S_STEP_WAIT,
    S_PIX_READ, S_PIX_WAIT, S_PIX_TEST, S_COL_START, S_COL_WAIT, S_PIX_WRITE,
    S_CLEAR, S_RD_WAIT, S_RD_DATA, S_RD_LATCH, S_DONE
  } state_t;

  state_t       state_r;
  cmd_t         c_r;
  logic [23:0]  cmem [StoreSize];
  logic [23:0]  dmem [StoreSize];
  logic [23:0]  crd_r;
  logic [23:0]  drd_r;
  logic [AddrW-1:0] addr_r;
  logic         we_r;
  logic [23:0]  wc_r;
  logic [23:0]  wd_r;

  logic signed [12:0] x_r;
  logic signed [12:0] e_r;
  logic [11:0]  n_r;
  logic [11:0]  interval_r;
  logic         chunk_r;
  logic [11:0]  ctr_r;
  logic [11:0]  written_r;
  logic [23:0]  col_r;
  logic [23:0]  dnew_r;
  logic [1:0]   ch_r;
  logic [7:0]   chv_r [3];
  logic         colneed_r;

  logic         dstart;
  logic [35:0]  dnum;
  logic [11:0]  dden;
  logic         ddone;
  logic [35:0]  dquo;
  logic         dsign_r;

  logic [9:0]   sum;
  logic signed [12:0] e_raw;
  logic [12:0]  s_val;
  logic [24:0]  ddelta;
  logic [8:0]   cdelta;
  logic [7:0]   cs_sel;
  logic [7:0]   ce_sel;
  logic [35:0]  prod_d;
  logic [19:0]  prod_c;
  logic [35:0]  fq;
  logic [AddrW-1:0] base;

  function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign sum = {2'b0, absd(c_r.rs, c_r.re)} + {2'b0, absd(c_r.gs, c_r.ge)}
             + {2'b0, absd(c_r.bs, c_r.be)};
  assign e_raw = 13'(c_r.x_start) + 13'(signed'({1'b0, c_r.span_length}));
  assign s_val = c_r.x_start[11] ? 13'd0 : 13'(c_r.x_start);
  assign base = AddrW'(c_r.row) * AddrW'(Width);

  assign ddelta = c_r.ide >= c_r.ids ? 25'(c_r.ide - c_r.ids) : 25'(c_r.ids - c_r.ide);
  always_comb begin
    case (ch_r)
      2'd0: begin cs_sel = c_r.rs; ce_sel = c_r.re; end
      2'd1: begin cs_sel = c_r.gs; ce_sel = c_r.ge; end
      default: begin cs_sel = c_r.bs; ce_sel = c_r.be; end
    endcase
  end
  assign cdelta = ce_sel >= cs_sel ? 9'(ce_sel - cs_sel) : 9'(cs_sel - ce_sel);
  assign prod_d = 36'(ddelta) * 36'(n_r);
  assign prod_c = 20'(cdelta) * 20'(n_r);
  // Floor of a negative quotient: magnitude rounded up, quotient is divided magnitude.
  assign fq = dquo;

  always_comb begin
    dstart = 1'b0;
    dnum = 36'd0;
    dden = 12'(c_r.span_length);
    case (state_r)
      S_SETUP: begin
        dstart = (sum != 10'd0);
        dnum = 36'(3 * 12'(c_r.span_length));
        dden = 12'(sum);
      end
      S_STEP_START: begin
        dstart = 1'b1;
        dnum = (c_r.ide >= c_r.ids) ? prod_d : prod_d + 36'(c_r.span_length) - 36'd1;
      end
      S_COL_START: begin
        dstart = 1'b1;
        dnum = (ce_sel >= cs_sel) ? 36'(prod_c)
             : 36'(prod_c) + 36'(c_r.span_length) - 36'd1;
      end
      default: ;
    endcase
  end

  gzsf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  always_ff @(posedge clk) begin
    if (we_r) begin
      cmem[addr_r] <= wc_r;
      dmem[addr_r] <= wd_r;
    end
    crd_r <= cmem[addr_r];
    drd_r <= dmem[addr_r];
  end

  assign q_take = (state_r == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      we_r <= 1'b0;
    end else begin
      we_r <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid && !out_valid) begin
            c_r <= q_cmd;
            written_r <= 12'd0;
            out_pixels_written <= 12'd0;
            out_read_color <= 24'd0;
            out_read_depth <= 24'd0;
            addr_r <= '0;
            case (func_t'(q_cmd.func))
              FUNC_DRAW: state_r <= S_SETUP;
              FUNC_CLEAR: state_r <= S_CLEAR;
              FUNC_READ: state_r <= S_RD_WAIT;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SETUP: begin
          x_r <= signed'(s_val);
          e_r <= (e_raw > 13'(Width - 1)) ? 13'(Width - 1) : e_raw;
          n_r <= 12'(signed'(s_val) - 13'(c_r.x_start));
          if (c_r.span_length == 11'd0 || c_r.row >= 8'(Height)) begin
            state_r <= S_DONE;
          end else if (sum == 10'd0) begin
            interval_r <= 12'(c_r.span_length);
            state_r <= S_IDIV;
          end else begin
            state_r <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (sum == 10'd0 || ddone) begin
            if (sum != 10'd0) begin
              // An interval that does not fit in 12 bits saturates; it still covers a whole span as one chunk.
              interval_r <= (|dquo[35:12]) ? 12'hFFF
                          : (dquo[11:0] < 12'(min_int)) ? 12'(min_int) : dquo[11:0];
            end
            state_r <= S_STEP_START;
          end
        end
        S_STEP_START: begin
          if (x_r == signed'(s_val)) begin
            chunk_r <= (interval_r > 12'(ChunkThreshold));
            ctr_r <= interval_r;
            colneed_r <= 1'b1;
          end
          if (x_r > e_r) state_r <= S_DONE;
          else begin
            dsign_r <= (c_r.ide < c_r.ids);
            state_r <= S_STEP_WAIT;
          end
        end
        S_STEP_WAIT: begin
          if (ddone) begin
            dnew_r <= dsign_r ? 24'(c_r.ids - fq[23:0]) : 24'(c_r.ids + fq[23:0]);
            addr_r <= base + AddrW'(x_r[11:0]);
            state_r <= S_PIX_READ;
          end
        end
        S_PIX_READ: state_r <= S_PIX_WAIT;
        S_PIX_WAIT: state_r <= S_PIX_TEST;
        S_PIX_TEST: begin
          ch_r <= 2'd0;
          if (chunk_r) begin
            if (colneed_r) state_r <= S_COL_START;
            else state_r <= S_PIX_WRITE;
          end else if (drd_r < dnew_r) begin
            if (ctr_r + 12'd1 > interval_r || x_r == e_r) begin
              state_r <= S_COL_START;
            end else begin
              ctr_r <= ctr_r + 12'd1;
              state_r <= S_PIX_WRITE;
            end
          end else begin
            state_r <= S_PIX_WRITE;
          end
        end
        S_COL_START: state_r <= S_COL_WAIT;
        S_COL_WAIT: begin
          if (ddone) begin
            chv_r[ch_r] <= (ce_sel >= cs_sel) ? 8'(cs_sel + fq[7:0]) : 8'(cs_sel - fq[7:0]);
            if (ch_r == 2'd2) begin
              colneed_r <= 1'b0;
              ctr_r <= 12'd0;
              state_r <= S_PIX_WRITE;
            end else begin
              ch_r <= ch_r + 2'd1;
              state_r <= S_COL_START;
            end
          end
        end
        S_PIX_WRITE: begin
          if (drd_r < dnew_r) begin
            we_r <= 1'b1;
            wd_r <= dnew_r;
            wc_r <= (ch_r == 2'd2) ? {chv_r[0], chv_r[1], chv_r[2]} : col_r;
            if (ch_r == 2'd2) col_r <= {chv_r[0], chv_r[1], chv_r[2]};
            written_r <= written_r + 12'd1;
          end else if (ch_r == 2'd2) begin
            col_r <= {chv_r[0], chv_r[1], chv_r[2]};
          end
          ch_r <= 2'd0;
          x_r <= x_r + 13'd1;
          n_r <= n_r + 12'd1;
          if (chunk_r) begin
            if (ctr_r == interval_r - 12'd1 || (ch_r == 2'd2 && interval_r == 12'd1)) begin
              colneed_r <= 1'b1;
              ctr_r <= 12'd0;
            end else begin
              ctr_r <= (ch_r == 2'd2) ? 12'd1 : ctr_r + 12'd1;
              if (ch_r == 2'd2 && interval_r == 12'd1) colneed_r <= 1'b1;
            end
          end
          if (x_r == e_r) state_r <= S_DONE;
          else state_r <= S_STEP_START;
        end
        S_CLEAR: begin
          we_r <= 1'b1;
          wc_r <= bg_color;
          wd_r <= 24'd0;
          if (we_r) addr_r <= addr_r + AddrW'(1);
          if (we_r && addr_r == AddrW'(StoreSize - 2)) state_r <= S_DONE;
          if (!we_r && addr_r != '0) state_r <= S_DONE;
        end
        S_RD_WAIT: begin
          addr_r <= base + AddrW'(c_r.x_start[10:0]);
          state_r <= S_RD_DATA;
        end
        S_RD_DATA: begin
          if (!c_r.x_start[11] && c_r.x_start < 12'(Width) && c_r.row < 8'(Height)) begin
            state_r <= S_RD_LATCH;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_RD_LATCH: begin
          out_read_color <= crd_r;
          out_read_depth <= drd_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_pixels_written <= written_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/gouraud_zbuffer_span_fill.sv
// ============================================================================
// gouraud_zbuffer_span_fill
// Gouraud-shaded span fill over a color store and an inverse-depth store.
// ============================================================================
//  channel | ports                          | direction
//  in      | in_valid/in_stall, fields      | words in
//  out     | out_valid/out_stall, fields    | words out
//  cfg     | psel/penable/pwrite/paddr      | registers
// A draw runs the serial divider for each column to step depth; a color
// recompute adds three divisions, one per channel, and setup adds one
// division for the color interval when the end colors differ. A clear
// sweeps the stores one entry per cycle. The stores hold nothing valid
// after reset until a clear. A two-entry queue accepts words until
// it is full, also while the back end works or is stalled.
`default_nettype none
module gouraud_zbuffer_span_fill
  import gzsf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic signed [11:0] in_x_start,
  input  wire logic [7:0]  in_row,
  input  wire logic [10:0] in_span_length,
  input  wire logic [23:0] in_inv_depth_start,
  input  wire logic [23:0] in_inv_depth_end,
  input  wire logic [7:0]  in_red_start,
  input  wire logic [7:0]  in_green_start,
  input  wire logic [7:0]  in_blue_start,
  input  wire logic [7:0]  in_red_end,
  input  wire logic [7:0]  in_green_end,
  input  wire logic [7:0]  in_blue_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_pixels_written,
  output logic [23:0]      out_read_color,
  output logic [23:0]      out_read_depth,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [7:0] bg_red_r;
  logic [7:0] bg_green_r;
  logic [7:0] bg_blue_r;
  logic [7:0] min_int_r;
  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_take;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_red_r <= 8'd0;
      bg_green_r <= 8'd0;
      bg_blue_r <= 8'd0;
      min_int_r <= 8'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        4'd0: bg_red_r <= pwdata[7:0];
        4'd4: bg_green_r <= pwdata[7:0];
        4'd8: bg_blue_r <= pwdata[7:0];
        4'd12: min_int_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      4'd0: prdata = {24'd0, bg_red_r};
      4'd4: prdata = {24'd0, bg_green_r};
      4'd8: prdata = {24'd0, bg_blue_r};
      4'd12: prdata = {24'd0, min_int_r};
      default: prdata = 32'd0;
    endcase
  end

  assign in_cmd = '{func: in_func, x_start: in_x_start, row: in_row,
                    span_length: in_span_length, ids: in_inv_depth_start,
                    ide: in_inv_depth_end, rs: in_red_start, gs: in_green_start,
                    bs: in_blue_start, re: in_red_end, ge: in_green_end,
                    be: in_blue_end};

  gzsf_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
  );

  gzsf_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
    .bg_color({bg_red_r, bg_green_r, bg_blue_r}), .min_int(min_int_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixels_written(out_pixels_written), .out_read_color(out_read_color),
    .out_read_depth(out_read_depth)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixels_written))
    else $error("result word changed under stall");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !q_take || q_valid)
    else $error("queue full but empty");
endmodule
`default_nettype wire
